>>> src/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and the control struct that the sequencer sends to every
// level cell of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 9;
    localparam int WLEN_MAX = 511;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd3;

    // per-cycle strobes broadcast along the chain
    typedef struct packed {
        logic adv;    // every cell hands its word to the next one
        logic add;    // increment cycle
        logic sub;    // decrement cycle
        logic clr;    // clearing pass writes zero
        logic flush;  // drop all words in flight
    } t_cell_ctl;

endpackage

>>> src/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One level of the count tree. Holds the counts of all nodes at LEVEL, adds
// the new sample, takes one step of the rank descent and removes the oldest
// sample, then hands the word to the next level.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int VALUE_BITS = 16,
    parameter int LEVEL      = 1,
    parameter int CNT_W      = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swm_pkg::t_cell_ctl    i_ctl,
    input  logic [LEVEL-1:0]      i_clr_addr,
    input  logic                  i_vld,
    input  logic                  i_emit,
    input  logic [VALUE_BITS-1:0] i_v,
    input  logic [VALUE_BITS-1:0] i_old,
    input  logic [CNT_W-1:0]      i_rank,
    input  logic [VALUE_BITS-1:0] i_path,
    output logic                  o_vld,
    output logic                  o_emit,
    output logic [VALUE_BITS-1:0] o_v,
    output logic [VALUE_BITS-1:0] o_old,
    output logic [CNT_W-1:0]      o_rank,
    output logic [VALUE_BITS-1:0] o_path
);

    localparam int DEPTH = 2 ** LEVEL;

    logic [CNT_W-1:0]      r_mem [DEPTH];
    logic [CNT_W-1:0]      r_rda;
    logic [CNT_W-1:0]      r_rdb;

    logic                  r_vld;
    logic                  r_emit;
    logic [VALUE_BITS-1:0] r_v;
    logic [VALUE_BITS-1:0] r_old;
    logic [CNT_W-1:0]      r_rank;
    logic [VALUE_BITS-1:0] r_path;

    logic [LEVEL-1:0]      v_node;
    logic [LEVEL-1:0]      old_node;
    logic [LEVEL-1:0]      left_node;
    logic [LEVEL-1:0]      rd_addr;
    logic [LEVEL-1:0]      wr_addr;
    logic                  wr_en;
    logic [CNT_W-1:0]      wr_data;
    logic [CNT_W-1:0]      cnt_left;
    logic                  same;

    assign v_node    = r_v[VALUE_BITS-1 -: LEVEL];
    assign old_node  = r_old[VALUE_BITS-1 -: LEVEL];
    // bit of this level in the path is still zero: this is the left child
    assign left_node = r_path[VALUE_BITS-1 -: LEVEL];

    // add and remove on the same node cancel
    assign same     = r_emit && (v_node == old_node);
    // left count as seen after the add, before the removal
    assign cnt_left = r_rdb + CNT_W'(v_node == left_node);
    assign rd_addr  = i_ctl.add ? old_node : v_node;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = v_node;
        wr_data = r_rda + 1'b1;
        if (i_ctl.clr) begin
            wr_en   = 1'b1;
            wr_addr = i_clr_addr;
            wr_data = '0;
        end else if (i_ctl.add && r_vld && !same) begin
            wr_en   = 1'b1;
            wr_addr = v_node;
            wr_data = r_rda + 1'b1;
        end else if (i_ctl.sub && r_vld && r_emit && !same) begin
            wr_en   = 1'b1;
            wr_addr = old_node;
            wr_data = r_rda - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rda <= r_mem[rd_addr];
        r_rdb <= r_mem[left_node];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.flush) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_emit <= i_emit;
            r_v    <= i_v;
            r_old  <= i_old;
            r_rank <= i_rank;
            r_path <= i_path;
        end else if (i_ctl.add && r_vld && r_emit) begin
            if (r_rank > cnt_left) begin
                r_rank                    <= r_rank - cnt_left;
                r_path[VALUE_BITS-LEVEL] <= 1'b1;
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_emit = r_emit;
    assign o_v    = r_v;
    assign o_old  = r_old;
    assign o_rank = r_rank;
    assign o_path = r_path;

endmodule

>>> src/sliding_window_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median
// Lower median over the last window_length samples, using a count tree with
// one cell per tree level and a delay line of the window samples.
// ----------------------------------------------------------------------------
// Each word passes the read, add and sub phases, and waits while the output
//   is stalled, before the next is accepted; each level memory is read,
//   incremented and decremented once per word. A median passes every level
//   cell in turn, one per chain advance, before it is registered on o_median.
// Reset and every window_length write start a clearing pass that zeroes every
//   level memory; no sample is accepted until it ends.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int VALUE_BITS = 16,
    parameter int MAX_WINDOW = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [swm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [swm_pkg::SAMPLE_W-1:0]  o_median,
    input  logic                          i_stall,
    input  logic                          i_cfg_we,
    input  logic [swm_pkg::WLEN_W-1:0]    i_cfg_data
);

    localparam int KMAX  = (MAX_WINDOW < swm_pkg::WLEN_MAX) ? MAX_WINDOW
                                                            : swm_pkg::WLEN_MAX;
    localparam int CNT_W = $clog2(KMAX + 1);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = PTR_W + 1;
    localparam int EXT_W = (VALUE_BITS > swm_pkg::SAMPLE_W) ? VALUE_BITS
                                                            : swm_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        PH_CLEAR,
        PH_READ,
        PH_ADD,
        PH_SUB,
        PH_WAIT
    } t_phase;

    t_phase                      r_ph;
    logic [VALUE_BITS-1:0]       r_clr_cnt;
    logic [swm_pkg::WLEN_W-1:0]  r_wlen;
    logic [CNT_W-1:0]            r_fill;
    logic [PTR_W-1:0]            r_ptr;

    logic [VALUE_BITS-1:0]       r_dl [MAX_WINDOW];
    logic [VALUE_BITS-1:0]       r_dl_rd;

    logic                        c_vld  [VALUE_BITS+1];
    logic                        c_emit [VALUE_BITS+1];
    logic [VALUE_BITS-1:0]       c_v    [VALUE_BITS+1];
    logic [VALUE_BITS-1:0]       c_old  [VALUE_BITS+1];
    logic [CNT_W-1:0]            c_rank [VALUE_BITS+1];
    logic [VALUE_BITS-1:0]       c_path [VALUE_BITS+1];

    swm_pkg::t_cell_ctl          ctl;

    logic [CNT_W-1:0]            k_eff;
    logic [CNT_W:0]              rank_w;
    logic [CNT_W-1:0]            fill_inc;
    logic                        emit;
    logic [SUM_W-1:0]            slot_sum;
    logic [PTR_W-1:0]            slot;
    logic [PTR_W-1:0]            ptr_next;
    logic [EXT_W-1:0]            smp_ext;
    logic [EXT_W-1:0]            med_ext;
    logic [VALUE_BITS-1:0]       v_in;
    logic                        can_out;
    logic                        adv_now;
    logic                        accept;

    // effective window: zero means one, saturate at the largest window
    always_comb begin
        if (r_wlen == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(r_wlen) > KMAX) begin
            k_eff = CNT_W'(KMAX);
        end else begin
            k_eff = CNT_W'(r_wlen);
        end
    end

    assign rank_w   = {1'b0, k_eff} + 1'b1;
    assign fill_inc = r_fill + 1'b1;
    assign emit     = (fill_inc == k_eff);

    assign slot_sum = SUM_W'(r_ptr) + SUM_W'(r_fill);
    assign slot     = (slot_sum >= SUM_W'(MAX_WINDOW))
                    ? PTR_W'(slot_sum - SUM_W'(MAX_WINDOW)) : PTR_W'(slot_sum);
    assign ptr_next = (r_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_ptr + 1'b1;

    assign smp_ext  = EXT_W'(i_sample);
    assign v_in     = smp_ext[VALUE_BITS-1:0];
    assign med_ext  = EXT_W'(c_path[VALUE_BITS]);

    assign can_out  = !(c_vld[VALUE_BITS] && c_emit[VALUE_BITS]) || !o_valid || !i_stall;
    assign adv_now  = ((r_ph == PH_SUB) || (r_ph == PH_WAIT)) && can_out && !i_cfg_we;
    assign accept   = adv_now && i_valid;
    assign o_stall  = !adv_now;

    assign ctl.adv   = adv_now;
    assign ctl.add   = (r_ph == PH_ADD);
    assign ctl.sub   = (r_ph == PH_SUB);
    assign ctl.clr   = (r_ph == PH_CLEAR);
    assign ctl.flush = i_cfg_we;

    // entry word; with an empty window the oldest sample is the new one
    assign c_vld[0]  = i_valid;
    assign c_emit[0] = emit;
    assign c_v[0]    = v_in;
    assign c_old[0]  = (r_fill == '0) ? v_in : r_dl_rd;
    assign c_rank[0] = rank_w[CNT_W:1];
    assign c_path[0] = '0;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dl[slot] <= v_in;
        end
        r_dl_rd <= r_dl[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph      <= PH_CLEAR;
            r_clr_cnt <= '0;
            r_wlen    <= swm_pkg::WLEN_RESET;
            r_fill    <= '0;
            r_ptr     <= '0;
            o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wlen    <= i_cfg_data;
                r_ph      <= PH_CLEAR;
                r_clr_cnt <= '0;
                r_fill    <= '0;
                r_ptr     <= '0;
            end else begin
                case (r_ph)
                    PH_CLEAR: begin
                        r_clr_cnt <= r_clr_cnt + 1'b1;
                        if (r_clr_cnt == '1) begin
                            r_ph <= PH_READ;
                        end
                    end
                    PH_READ: r_ph <= PH_ADD;
                    PH_ADD:  r_ph <= PH_SUB;
                    PH_SUB, PH_WAIT: begin
                        r_ph <= adv_now ? PH_READ : PH_WAIT;
                    end
                    default: r_ph <= PH_CLEAR;
                endcase
                if (accept) begin
                    if (emit) begin
                        r_ptr <= ptr_next;
                    end else begin
                        r_fill <= fill_inc;
                    end
                end
            end

            if (adv_now && c_vld[VALUE_BITS] && c_emit[VALUE_BITS]) begin
                o_valid  <= 1'b1;
                o_median <= med_ext[swm_pkg::SAMPLE_W-1:0];
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < VALUE_BITS; g++) begin : g_cell
        swm_cell #(
            .VALUE_BITS (VALUE_BITS),
            .LEVEL      (g + 1),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_clr_addr (r_clr_cnt[g:0]),
            .i_vld      (c_vld[g]),
            .i_emit     (c_emit[g]),
            .i_v        (c_v[g]),
            .i_old      (c_old[g]),
            .i_rank     (c_rank[g]),
            .i_path     (c_path[g]),
            .o_vld      (c_vld[g+1]),
            .o_emit     (c_emit[g+1]),
            .o_v        (c_v[g+1]),
            .o_old      (c_old[g+1]),
            .o_rank     (c_rank[g+1]),
            .o_path     (c_path[g+1])
        );
    end

endmodule

>>> src/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the sliding window median filter: output hold, input
// cadence, and stall after a window_length write.
// ----------------------------------------------------------------------------
module swm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic [swm_pkg::SAMPLE_W-1:0] o_median,
    input logic                         i_stall,
    input logic                         i_cfg_we
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_median))
        else $error("stalled median word changed");

    // each word passes the read and add phases in a level cell before the input opens again
    a_in_cadence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("input word accepted too soon after the previous one");

    // a window_length write starts the clearing pass
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("input not stalled after window_length write");

    // a result only appears on a chain advance, which also opens the input
    a_out_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_stall))
        else $error("median word appeared without a chain advance");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .o_median (o_median),
    .i_stall  (i_stall),
    .i_cfg_we (i_cfg_we)
);

>>> tb/swm_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_median_checker
// Watches the sample, median and window_length ports of the median filter.
// It keeps its own copy of the window, works out the lower median for every
// accepted sample once the window is full, and compares each median that
// leaves the block with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module swm_median_checker #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0] i_median,
    input  logic                         i_cfg_we,
    input  logic [swm_pkg::WLEN_W-1:0]   i_cfg_data,
    output int                           o_mismatches,
    output int                           o_pending
);

    typedef logic [swm_pkg::SAMPLE_W-1:0] t_sample;

    logic [swm_pkg::WLEN_W-1:0] window_len = swm_pkg::WLEN_RESET;
    t_sample           window_fifo[$];    // arrival order, oldest first
    t_sample           window_sorted[$];  // same samples, ascending
    t_sample           median_q[$];
    int                mismatch_cnt = 0;

    // zero means one sample, anything past the delay line saturates
    function automatic int window_span(input logic [swm_pkg::WLEN_W-1:0] wlen);
        if (wlen == '0) return 1;
        if (int'(wlen) > MAX_WINDOW) return MAX_WINDOW;
        return int'(wlen);
    endfunction

    always @(posedge i_clk) begin
        t_sample expected_median;
        t_sample oldest;
        int      pos;
        int      span;
        if (!i_rst_n) begin
            window_len = swm_pkg::WLEN_RESET;
            window_fifo.delete();
            window_sorted.delete();
            median_q.delete();
            mismatch_cnt = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (median_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: median %0d arrived with none outstanding",
                                 $time, i_median);
                end else begin
                    expected_median = median_q.pop_front();
                    if (i_median !== expected_median) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: median expected %0d, got %0d",
                                     $time, expected_median, i_median);
                    end
                end
            end

            // any window_length write flushes the window
            if (i_cfg_we) begin
                window_len = i_cfg_data;
                window_fifo.delete();
                window_sorted.delete();
            end

            if (i_in_valid && !i_in_stall) begin
                span = window_span(window_len);
                pos = 0;
                while (pos < window_sorted.size() && window_sorted[pos] < i_sample)
                    pos++;
                window_sorted.insert(pos, i_sample);
                window_fifo.push_back(i_sample);
                if (window_fifo.size() >= span) begin
                    median_q.push_back(window_sorted[(span + 1) / 2 - 1]);
                    oldest = window_fifo.pop_front();
                    pos = 0;
                    while (window_sorted[pos] != oldest)
                        pos++;
                    window_sorted.delete(pos);
                end
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= median_q.size();
    end

endmodule

>>> tb/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// Drives edge samples and then random bursts into the median filter over a
// series of window lengths, stalls the median output on a changing pattern,
// and lets the checker compare every median. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;

    localparam int VALUE_BITS     = 16;
    localparam int MAX_WINDOW     = 256;
    localparam int DRAIN_CYCLES   = 4 * 3 * VALUE_BITS;
    localparam int WATCHDOG_LIMIT = 4 * (2 ** VALUE_BITS) + 20000;

    typedef logic [swm_pkg::SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    t_sample           i_sample   = '0;
    logic              o_stall;
    logic              o_valid;
    t_sample           o_median;
    logic              i_stall    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [swm_pkg::WLEN_W-1:0] i_cfg_data = '0;

    int          mismatches;
    int          pending;
    int          idle_cycles = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    logic [7:0]  stall_phase = '0;

    t_sample edge_samples[$] = '{
        16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA, 16'h0001,
        16'h7FFF, 16'hFFFE, 16'd10,   16'd20,   16'd30,   16'd20,
        16'd10,   16'd7,    16'd7,    16'd3
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sliding_window_median #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sample   (i_sample),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_median   (o_median),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    swm_median_checker #(
        .MAX_WINDOW (MAX_WINDOW)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_median     (o_median),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // output back-pressure, a new pattern is picked each time the 8-bit stall_phase counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_phase <= '0;
        end else begin
            stall_phase <= stall_phase + 8'd1;
            if (stall_phase == '0)
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_RANDOM:   i_stall <= ($urandom_range(0, 1) == 1);
                STALL_PERIODIC: i_stall <= (stall_phase[2:0] < 3'd3);
                default:        i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // watchdog, with a limit above the clearing pass that holds o_stall after reset and each write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 4))
            0:       return t_sample'($urandom_range(0, 7));
            1:       return t_sample'($urandom_range(65528, 65535));
            2:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // call right after a rising edge; returns after the first edge at which o_stall reads low
    task automatic push_sample(input t_sample value);
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) push_sample(pick_sample());
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // a partial window may still be in flight after the last median
    task automatic set_window(input logic [swm_pkg::WLEN_W-1:0] wlen);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= wlen;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [swm_pkg::WLEN_W-1:0] plan_len[$];
        int                plan_items[$];
        plan_len   = '{9'd0, 9'd1, 9'd2, 9'd256, 9'd511, 9'd0};
        plan_len[5] = swm_pkg::WLEN_W'($urandom_range(4, 64));
        plan_items = '{40, 40, 60, 280, 270, 100};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window of three from reset
        foreach (edge_samples[n]) push_sample(edge_samples[n]);
        i_valid <= 1'b0;
        send_random(20);
        wait_drained();
        send_random(20);

        foreach (plan_len[n]) begin
            set_window(plan_len[n]);
            send_random(plan_items[n]);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median.sv
src/swm_checker.sv
tb/swm_median_checker.sv
tb/sliding_window_median_tb.sv
